[hdl/egc_pkg.sv]
package egc_pkg;

    localparam int unsigned ODD_W   = 7;
    localparam logic [ODD_W-1:0] ODD_MAX = 7'd127;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_B,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_WALK_INIT,
        ST_POP,
        ST_LOAD_CUR,
        ST_LOAD_ROW,
        ST_PUSH,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_PATH    = 2'd1,
        VERDICT_CIRCUIT = 2'd2
    } t_verdict;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic stats_clear;
        logic scan_rd;
        logic walk_init;
        logic pop;
        logic walk_rd;
        logic load_mask;
        logic push;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic edge_ok;
        logic scan_last;
        logic stack_empty;
        logic mask_zero;
        logic out_free;
    } t_status;

endpackage

[hdl/egc_if.sv]
interface egc_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] node_a;
    logic [5:0] node_b;
    logic       edge_valid;
    logic       last_edge;

    modport source (output valid, output node_a, output node_b, output edge_valid,
                    output last_edge, input ready);
    modport sink   (input valid, input node_a, input node_b, input edge_valid,
                    input last_edge, output ready);
endinterface

interface egc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       connected;
    logic [6:0] odd_nodes;

    modport source (output valid, output verdict, output connected, output odd_nodes,
                    input ready);
    modport sink   (input valid, input verdict, input connected, input odd_nodes,
                    output ready);
endinterface

[hdl/eulerian_graph_classifier_unit.sv]
// An item with an in-range edge writes one adjacency row per endpoint, one after the other;
// an item without an in-range edge writes nothing.
// The last item starts a scan of all NODES rows on the shared adjacency read port; a walk then
// pops each reached node, reads its row, pushes unvisited neighbours, then posts the result.
// One graph at a time; a new graph loads while the result waits in its register.
// Reset: synchronous active low; reset clears the row valid bits, so there is no clearing pass.
module eulerian_graph_classifier_unit
    import egc_pkg::*;
#(
    parameter int NODES = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    egc_in_if.sink   i_in,
    egc_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    egc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_last   (i_in.last_edge),
        .o_ready  (i_in.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    egc_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_node_a     (i_in.node_a),
        .i_node_b     (i_in.node_b),
        .i_edge_valid (i_in.edge_valid),
        .i_out_ready  (o_out.ready),
        .o_valid      (o_out.valid),
        .o_verdict    (o_out.verdict),
        .o_connected  (o_out.connected),
        .o_odd_nodes  (o_out.odd_nodes)
    );

endmodule

[hdl/egc_ctrl.sv]
module egc_ctrl
    import egc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_status.edge_ok) begin
                        o_cmd.wr_a = 1'b1;
                        n_last     = i_last;
                        n_state    = ST_WR_B;
                    end else if (i_last) begin
                        o_cmd.stats_clear = 1'b1;
                        n_state           = ST_SCAN;
                    end
                end
            end
            ST_WR_B: begin
                o_cmd.wr_b = 1'b1;
                if (r_last) begin
                    o_cmd.stats_clear = 1'b1;
                    n_state           = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL: begin
                n_state = ST_WALK_INIT;
            end
            ST_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state         = ST_POP;
            end
            ST_POP: begin
                if (i_status.stack_empty) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_LOAD_CUR;
                end
            end
            ST_LOAD_CUR: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = ST_LOAD_ROW;
            end
            ST_LOAD_ROW: begin
                o_cmd.load_mask = 1'b1;
                n_state         = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_status.mask_zero) begin
                    n_state = ST_POP;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/egc_datapath.sv]
module egc_datapath
    import egc_pkg::*;
#(
    parameter int NODES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic [5:0]       i_node_a,
    input  logic [5:0]       i_node_b,
    input  logic             i_edge_valid,
    input  logic             i_out_ready,
    output logic             o_valid,
    output logic [1:0]       o_verdict,
    output logic             o_connected,
    output logic [ODD_W-1:0] o_odd_nodes
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DW = $clog2(NODES + 1);

    function automatic logic [IW-1:0] f_first(input logic [NODES-1:0] m);
        logic [IW-1:0] idx;
        idx = '0;
        for (int j = NODES - 1; j >= 0; j--) begin
            if (m[j]) begin
                idx = IW'(j);
            end
        end
        return idx;
    endfunction

    logic [NODES-1:0] r_adj [NODES];
    logic [IW-1:0]    r_stk [NODES];

    logic [NODES-1:0] r_row_vld;
    logic [NODES-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_row;
    logic             r_scan_q;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    r_a;
    logic [IW-1:0]    r_b;
    logic [NODES-1:0] r_has_edge;
    logic [NODES-1:0] r_visited;
    logic             r_found;
    logic [IW-1:0]    r_start;
    logic [ODD_W-1:0] r_odd;
    logic [DW-1:0]    r_depth;
    logic [IW-1:0]    r_stk_q;
    logic [NODES-1:0] r_mask;
    logic             r_o_valid;
    t_verdict         r_verdict;
    logic             r_connected;
    logic [ODD_W-1:0] r_odd_out;

    logic             w_en;
    logic [IW-1:0]    w_row;
    logic [IW-1:0]    w_bit;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic [NODES-1:0] row_eff;
    logic [IW-1:0]    start;
    logic [IW-1:0]    push_node;
    logic             stk_we;
    logic [IW-1:0]    stk_waddr;
    logic [IW-1:0]    stk_wdata;
    logic             conn;
    t_verdict         verdict;

    assign w_en    = i_cmd.wr_a | i_cmd.wr_b;
    assign w_row   = i_cmd.wr_a ? IW'(i_node_a) : r_b;
    assign w_bit   = i_cmd.wr_a ? IW'(i_node_b) : r_a;
    assign rd_en   = i_cmd.scan_rd | i_cmd.walk_rd;
    assign rd_addr = i_cmd.scan_rd ? r_idx : r_stk_q;
    assign row_eff = r_rd_vld ? r_rd_data : '0;
    assign start   = r_found ? r_start : '0;
    assign push_node = f_first(r_mask);

    assign stk_we    = i_cmd.walk_init | i_cmd.push;
    assign stk_waddr = i_cmd.walk_init ? '0 : r_depth[IW-1:0];
    assign stk_wdata = i_cmd.walk_init ? start : push_node;

    assign conn = ((r_has_edge & ~r_visited) == '0);

    always_comb begin
        if (!conn) begin
            verdict = VERDICT_NONE;
        end else if (r_odd == '0) begin
            verdict = VERDICT_CIRCUIT;
        end else if (r_odd == ODD_W'(2)) begin
            verdict = VERDICT_PATH;
        end else begin
            verdict = VERDICT_NONE;
        end
    end

    assign o_status.edge_ok     = i_edge_valid && (32'(i_node_a) < NODES)
                                  && (32'(i_node_b) < NODES);
    assign o_status.scan_last   = (r_idx == IW'(NODES - 1));
    assign o_status.stack_empty = (r_depth == '0);
    assign o_status.mask_zero   = (r_mask == '0);
    assign o_status.out_free    = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NODES; j++) begin
                if (!r_row_vld[w_row] || (IW'(j) == w_bit)) begin
                    r_adj[w_row][j] <= (IW'(j) == w_bit);
                end
            end
        end
        if (rd_en) begin
            r_rd_data <= r_adj[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_waddr] <= stk_wdata;
        end
        if (i_cmd.pop) begin
            r_stk_q <= r_stk[IW'(r_depth - DW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_a <= IW'(i_node_a);
            r_b <= IW'(i_node_b);
        end
        if (rd_en) begin
            r_rd_vld <= r_row_vld[rd_addr];
            r_rd_row <= rd_addr;
        end
        if (i_cmd.load_mask) begin
            r_mask <= row_eff & ~r_visited;
        end else if (i_cmd.push) begin
            r_mask[push_node] <= 1'b0;
        end
        if (r_scan_q && (|row_eff) && !r_found) begin
            r_start <= r_rd_row;
        end
        if (i_cmd.finish) begin
            r_verdict   <= verdict;
            r_connected <= conn;
            r_odd_out   <= r_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld  <= '0;
            r_scan_q   <= 1'b0;
            r_idx      <= '0;
            r_has_edge <= '0;
            r_visited  <= '0;
            r_found    <= 1'b0;
            r_odd      <= '0;
            r_depth    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_scan_q <= i_cmd.scan_rd;
            if (i_cmd.finish) begin
                r_row_vld <= '0;
            end else if (w_en) begin
                r_row_vld[w_row] <= 1'b1;
            end
            if (i_cmd.stats_clear) begin
                r_idx      <= '0;
                r_has_edge <= '0;
                r_visited  <= '0;
                r_found    <= 1'b0;
                r_odd      <= '0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (r_scan_q) begin
                    if (|row_eff) begin
                        r_has_edge[r_rd_row] <= 1'b1;
                        r_found              <= 1'b1;
                    end
                    if ((^row_eff) && (r_odd != ODD_MAX)) begin
                        r_odd <= r_odd + ODD_W'(1);
                    end
                end
                if (i_cmd.finish) begin
                    r_visited <= '0;
                end else if (i_cmd.walk_init) begin
                    r_visited[start] <= 1'b1;
                end else if (i_cmd.push) begin
                    r_visited[push_node] <= 1'b1;
                end
            end
            if (i_cmd.walk_init) begin
                r_depth <= DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= r_depth - DW'(1);
            end else if (i_cmd.push) begin
                r_depth <= r_depth + DW'(1);
            end
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_verdict   = r_verdict;
    assign o_connected = r_connected;
    assign o_odd_nodes = r_odd_out;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_depth < DW'(NODES)))
        else $error("stack push with no room");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_row_vld == '0) && (r_visited == '0))
        else $error("matrix or visited set not cleared after result");

    a_circuit_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_verdict == VERDICT_CIRCUIT)) |-> (r_connected && (r_odd_out == '0)))
        else $error("circuit verdict with odd nodes or disconnected graph");

endmodule
